// ===== design/tnb_pkg.sv =====
// Shared types, codes, constants and saturation helpers of the tanh neuron unit.
`timescale 1ns / 1ps
package tnb_pkg;

    localparam int CONNECTIONS_DEF = 16;

    // request codes
    localparam logic [2:0] REQ_FWD   = 3'd0;
    localparam logic [2:0] REQ_OGRAD = 3'd1;
    localparam logic [2:0] REQ_HGRAD = 3'd2;
    localparam logic [2:0] REQ_UPD   = 3'd3;
    localparam logic [2:0] REQ_LOAD  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACT  = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_WGT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LEARN_RATE  = 2'd0;
    localparam logic [1:0] CFG_MOMENTUM    = 2'd1;
    localparam logic [1:0] CFG_BIAS_WEIGHT = 2'd2;
    localparam logic [1:0] CFG_BIAS_INPUT  = 2'd3;

    localparam logic [16:0]        LEARN_RATE_RST  = 17'd9830;
    localparam logic [16:0]        MOMENTUM_RST    = 17'd32768;
    localparam logic signed [23:0] BIAS_WEIGHT_RST = 24'sd65536;
    localparam logic signed [23:0] BIAS_INPUT_RST  = 24'sd65536;

    localparam logic signed [32:0] Q16_ONE   = 33'sd65536;
    localparam logic [32:0]        TANH_SAT  = 33'd196608;
    localparam logic [23:0]        TANH_K27  = 24'd1769472;

    // tanh divider widths: numerator below 2^40, denominator below 2^23
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 23;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         conn_index;
        logic signed [23:0] operand_a;
        logic signed [23:0] operand_b;
        logic               last_term;
    } t_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [3:0]         result_index;
        logic signed [23:0] result_value;
    } t_rsp;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'sh0_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -49'sh0_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
        logic signed [23:0] r;
        if (v > 66'sd8388607) begin
            r = 24'sh7F_FFFF;
        end else if (v < -66'sd8388608) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== design/tnb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tnb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tnb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tanh ratio.
`timescale 1ns / 1ps
module tnb_div
    import tnb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_sub;
    logic              fits;

    assign rem_sh  = {r_rem, r_quo[DIV_NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/tanh_neuron_backprop_unit.sv =====
// Top level of the tanh neuron unit: sequencer, shared multiplier and weight memories.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on i_req with start; a request is taken at a clock edge
//   where start is high and busy is low. Each request runs alone; busy stays
//   high until its work is done.
//   Results leave on o_rsp, marked by o_valid for exactly one cycle. The
//   receiver cannot stall, so every result must be taken when it shows.
//   A result shows in the first cycle with busy low, and a new request may be
//   taken in that same cycle.
//   Steps per request (start to busy low); one shared 33x33 multiplier takes
//   every product but the tanh denominator's, one product per cycle:
//     load or ignored request ......... taken in idle, no busy
//     forward term, not last .......... product, accumulate
//     forward last, saturated tanh .... plus bias term and rail check
//     forward last, tanh ratio ........ plus square, numerator, bit-serial divider
//     output gradient ................. value squared, slope, gradient product
//     hidden term, not last / last .... product, accumulate / plus gradient
//     weight update ................... read, three products, write back
//   Outgoing weights and weight changes live in two RAMs with registered
//   read; the update reads both, modifies and writes them back.
//   Weight changes carry a valid bit per entry, so reset reads them as zero.
//   Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at once
//   and are only to be made while the unit is idle.
//   Synchronous reset restores the configuration defaults and clears node
//   value, gradient, accumulator and the weight-change valid bits.
module tanh_neuron_backprop_unit
    import tnb_pkg::*;
#(
    parameter int CONNECTIONS = CONNECTIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_req        i_req,
    output logic        busy,
    output logic        o_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_FWD_MUL, S_FWD_ACC, S_FWD_BIAS, S_FWD_TANH,
        S_TH_SQ, S_TH_NUM, S_TH_GO, S_TH_DIV,
        S_OMS_MUL, S_OMS, S_GRD_MUL, S_GRD_OUT,
        S_HID_MUL, S_HID_ACC,
        S_UPD_LR, S_UPD_P, S_UPD_M, S_UPD_WB
    } t_state;

    t_state r_state;

    // configuration
    logic [16:0]        r_learn_rate;
    logic [16:0]        r_momentum;
    logic signed [23:0] r_bias_weight;
    logic signed [23:0] r_bias_input;

    // neuron state and working registers
    logic signed [23:0] r_node_value;
    logic signed [23:0] r_node_grad;
    logic signed [47:0] r_acc;
    t_req               r_req;
    logic               r_idx_ok;
    logic signed [65:0] r_prod;
    logic signed [32:0] r_oms;
    logic [17:0]        r_mag;
    logic               r_neg;
    logic [DIV_DW-1:0]  r_den;
    logic signed [32:0] r_p2;
    logic signed [23:0] r_w;
    logic signed [23:0] r_dlt;
    logic [15:0]        r_dvld;
    logic               r_valid;
    t_rsp               r_rsp;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] prod_q;
    logic signed [47:0] acc_sum;
    logic signed [31:0] acc_q;
    logic signed [32:0] x_mag;
    logic [19:0]        x2;
    logic [23:0]        den_full;
    logic signed [23:0] w_hid;
    logic signed [23:0] upd_nd;
    logic signed [23:0] upd_w;
    logic               in_idx_ok;

    // RAM ports
    logic              wgt_we;
    logic              dlt_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [23:0]       wgt_wdata;
    logic [23:0]       dlt_wdata;
    logic [23:0]       wgt_rdata;
    logic [23:0]       dlt_rdata;

    // divider
    logic              div_start;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;

    assign in_idx_ok = 32'(i_req.conn_index) < CONNECTIONS;
    assign prod_q    = r_prod >>> 16;
    assign acc_sum   = sat48(49'(r_acc) + 49'($signed(r_prod[47:0])));
    assign acc_q     = $signed(r_acc[47:16]);
    assign x_mag     = acc_q[31] ? -33'(acc_q) : 33'(acc_q);
    assign x2        = r_prod[35:16];
    assign den_full  = TANH_K27 + 24'(x2) * 24'd9;
    assign w_hid     = r_idx_ok ? $signed(wgt_rdata) : 24'sd0;
    assign upd_nd    = sat24(66'(r_p2) + 66'($signed(prod_q[32:0])));
    assign upd_w     = sat24(66'(r_w) + 66'(upd_nd));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_FWD_MUL: begin
                mul_a = 33'(r_req.operand_a);
                mul_b = 33'(r_req.operand_b);
            end
            S_FWD_ACC: begin
                mul_a = 33'(r_bias_weight);
                mul_b = 33'(r_bias_input);
            end
            S_TH_SQ: begin
                mul_a = $signed({15'd0, r_mag});
                mul_b = $signed({15'd0, r_mag});
            end
            S_TH_NUM: begin
                mul_a = $signed({15'd0, r_mag});
                mul_b = $signed({11'd0, TANH_K27[21:0] + 22'(x2)});
            end
            S_OMS_MUL: begin
                mul_a = 33'(r_node_value);
                mul_b = 33'(r_node_value);
            end
            S_GRD_MUL: begin
                mul_a = (r_req.req_type == REQ_OGRAD)
                      ? 33'(r_req.operand_a) - 33'(r_node_value)
                      : 33'(acc_q);
                mul_b = r_oms;
            end
            S_HID_MUL: begin
                mul_a = 33'(w_hid);
                mul_b = 33'(r_req.operand_a);
            end
            S_UPD_LR: begin
                mul_a = $signed({16'd0, r_learn_rate});
                mul_b = 33'(r_node_value);
            end
            S_UPD_P: begin
                mul_a = $signed(prod_q[32:0]);
                mul_b = 33'(r_req.operand_a);
            end
            S_UPD_M: begin
                mul_a = $signed({16'd0, r_momentum});
                mul_b = 33'(r_dlt);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // memory access: loads write in idle, updates write back at the end
    always_comb begin
        wgt_we    = 1'b0;
        dlt_we    = 1'b0;
        wgt_wdata = i_req.operand_a;
        dlt_wdata = '0;
        ram_waddr = AW'(i_req.conn_index);
        ram_raddr = (r_state == S_IDLE) ? AW'(i_req.conn_index) : AW'(r_req.conn_index);
        if (r_state == S_IDLE) begin
            if (start && i_req.req_type == REQ_LOAD && in_idx_ok) begin
                wgt_we = 1'b1;
                dlt_we = 1'b1;
            end
        end else if (r_state == S_UPD_WB) begin
            wgt_we    = 1'b1;
            dlt_we    = 1'b1;
            wgt_wdata = upd_w;
            dlt_wdata = upd_nd;
            ram_waddr = AW'(r_req.conn_index);
        end
    end

    assign div_start = (r_state == S_TH_GO);

    tnb_ram #(.WIDTH(24), .DEPTH(CONNECTIONS)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (ram_waddr),
        .i_wdata (wgt_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (wgt_rdata)
    );

    tnb_ram #(.WIDTH(24), .DEPTH(CONNECTIONS)) u_dlt_ram (
        .i_clk   (i_clk),
        .i_we    (dlt_we),
        .i_waddr (ram_waddr),
        .i_wdata (dlt_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (dlt_rdata)
    );

    tnb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod[DIV_NW-1:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate  <= LEARN_RATE_RST;
            r_momentum    <= MOMENTUM_RST;
            r_bias_weight <= BIAS_WEIGHT_RST;
            r_bias_input  <= BIAS_INPUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEARN_RATE:  r_learn_rate  <= i_cfg_data[16:0];
                CFG_MOMENTUM:    r_momentum    <= i_cfg_data[16:0];
                CFG_BIAS_WEIGHT: r_bias_weight <= $signed(i_cfg_data);
                CFG_BIAS_INPUT:  r_bias_input  <= $signed(i_cfg_data);
            endcase
        end
    end

    // sequencer with registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_node_value <= '0;
            r_node_grad  <= '0;
            r_acc        <= '0;
            r_dvld       <= '0;
        end else begin
            r_valid <= 1'b0;
            r_prod  <= mul_p;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req    <= i_req;
                        r_idx_ok <= in_idx_ok;
                        unique case (i_req.req_type)
                            REQ_FWD:   r_state <= S_FWD_MUL;
                            REQ_OGRAD: r_state <= S_OMS_MUL;
                            REQ_HGRAD: r_state <= S_HID_MUL;
                            REQ_UPD:   r_state <= in_idx_ok ? S_UPD_LR : S_IDLE;
                            REQ_LOAD: begin
                                if (in_idx_ok) begin
                                    r_dvld[i_req.conn_index] <= 1'b1;
                                end
                            end
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FWD_MUL: r_state <= S_FWD_ACC;
                S_FWD_ACC: begin
                    r_acc   <= acc_sum;
                    r_state <= r_req.last_term ? S_FWD_BIAS : S_IDLE;
                end
                S_FWD_BIAS: begin
                    r_acc   <= acc_sum;
                    r_state <= S_FWD_TANH;
                end
                S_FWD_TANH: begin
                    r_acc <= '0;
                    r_neg <= acc_q[31];
                    r_mag <= x_mag[17:0];
                    if ($unsigned(x_mag) >= TANH_SAT) begin
                        r_node_value              <= acc_q[31] ? -24'sd65536 : 24'sd65536;
                        r_rsp.result_kind         <= KIND_ACT;
                        r_rsp.result_index        <= '0;
                        r_rsp.result_value        <= acc_q[31] ? -24'sd65536 : 24'sd65536;
                        r_valid                   <= 1'b1;
                        r_state                   <= S_IDLE;
                    end else begin
                        r_state <= S_TH_SQ;
                    end
                end
                S_TH_SQ: r_state <= S_TH_NUM;
                S_TH_NUM: begin
                    r_den   <= den_full[DIV_DW-1:0];
                    r_state <= S_TH_GO;
                end
                S_TH_GO: r_state <= S_TH_DIV;
                S_TH_DIV: begin
                    if (div_done) begin
                        r_node_value <= r_neg ? -$signed({6'd0, div_quo[17:0]})
                                              : $signed({6'd0, div_quo[17:0]});
                        r_rsp.result_kind  <= KIND_ACT;
                        r_rsp.result_index <= '0;
                        r_rsp.result_value <= r_neg ? -$signed({6'd0, div_quo[17:0]})
                                                    : $signed({6'd0, div_quo[17:0]});
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OMS_MUL: r_state <= S_OMS;
                S_OMS: begin
                    r_oms   <= Q16_ONE - $signed(prod_q[32:0]);
                    r_state <= S_GRD_MUL;
                end
                S_GRD_MUL: begin
                    if (r_req.req_type == REQ_HGRAD) begin
                        r_acc <= '0;
                    end
                    r_state <= S_GRD_OUT;
                end
                S_GRD_OUT: begin
                    r_node_grad        <= sat24(prod_q);
                    r_rsp.result_kind  <= KIND_GRAD;
                    r_rsp.result_index <= '0;
                    r_rsp.result_value <= sat24(prod_q);
                    r_valid            <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_HID_MUL: r_state <= S_HID_ACC;
                S_HID_ACC: begin
                    r_acc   <= acc_sum;
                    r_state <= r_req.last_term ? S_OMS_MUL : S_IDLE;
                end
                S_UPD_LR: begin
                    r_w     <= $signed(wgt_rdata);
                    r_dlt   <= r_dvld[r_req.conn_index] ? $signed(dlt_rdata) : 24'sd0;
                    r_state <= S_UPD_P;
                end
                S_UPD_P: r_state <= S_UPD_M;
                S_UPD_M: begin
                    r_p2    <= $signed(prod_q[32:0]);
                    r_state <= S_UPD_WB;
                end
                S_UPD_WB: begin
                    r_dvld[r_req.conn_index] <= 1'b1;
                    r_rsp.result_kind        <= KIND_WGT;
                    r_rsp.result_index       <= r_req.conn_index;
                    r_rsp.result_value       <= upd_w;
                    r_valid                  <= 1'b1;
                    r_state                  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== test/tanh_neuron_backprop_unit_test.sv =====
// Self-checking testbench of the tanh neuron unit: queued requests, predicted results, field checks.
`timescale 1ns / 1ps
module tanh_neuron_backprop_unit_test;
    import tnb_pkg::*;

    localparam int  N_CONN    = CONNECTIONS_DEF;
    localparam int  SETTLE    = 80;     // longer than the slowest request (tanh divide)
    localparam int  STALL_MAX = 5000;   // cycles without any handshake before giving up
    localparam longint Q_MAX  = 8388607;
    localparam longint Q_MIN  = -8388608;
    localparam longint A_MAX  = 64'sd140737488355327;
    localparam longint A_MIN  = -64'sd140737488355328;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_req        i_req;
    logic        busy;
    logic        o_valid;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    tanh_neuron_backprop_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Requests waiting to be issued, and results owed by the unit.
    t_req   pending_reqs[$];
    t_rsp   owed_results[$];

    // Mirror of the neuron: configuration and state.
    longint rate, mom, bias_w, bias_in;
    longint node_act, node_grad, acc;
    longint out_w[N_CONN];
    longint w_delta[N_CONN];

    int     errors;
    int     n_taken;
    int     n_checked;
    int     quiet_cycles;
    bit     req_taken;
    int     burst_left;
    int     gap_left;

    function automatic longint clamp24(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > A_MAX) return A_MAX;
        if (v < A_MIN) return A_MIN;
        return v;
    endfunction

    // 1 - v^2 in Q16
    function automatic longint slope(input longint v);
        return 65536 - ((v * v) >>> 16);
    endfunction

    // rational tanh approximation, saturating to +-1 beyond |x| = 3
    function automatic longint tanh_q(input longint x);
        longint mag, x2, r;
        mag = (x < 0) ? -x : x;
        if (mag >= 196608) return (x < 0) ? -65536 : 65536;
        x2 = (mag * mag) >>> 16;
        r  = (mag * (27 * 65536 + x2)) / (27 * 65536 + 9 * x2);
        return (x < 0) ? -r : r;
    endfunction

    // Advance the mirror by one request; return 1 with the result when one is due.
    function automatic bit neuron_step(input t_req r, output t_rsp y);
        longint a, b, p, m, nd;
        int     k;
        a = longint'(r.operand_a);
        b = longint'(r.operand_b);
        k = int'(r.conn_index);
        y = '0;
        case (r.req_type)
            REQ_FWD: begin
                acc = clamp48(acc + a * b);
                if (!r.last_term) return 1'b0;
                acc = clamp48(acc + bias_w * bias_in);
                node_act = tanh_q(acc >>> 16);
                acc = 0;
                y.result_kind  = KIND_ACT;
                y.result_value = node_act[23:0];
                return 1'b1;
            end
            REQ_OGRAD: begin
                node_grad = clamp24(((a - node_act) * slope(node_act)) >>> 16);
                y.result_kind  = KIND_GRAD;
                y.result_value = node_grad[23:0];
                return 1'b1;
            end
            REQ_HGRAD: begin
                acc = clamp48(acc + out_w[k] * a);
                if (!r.last_term) return 1'b0;
                node_grad = clamp24(((acc >>> 16) * slope(node_act)) >>> 16);
                acc = 0;
                y.result_kind  = KIND_GRAD;
                y.result_value = node_grad[23:0];
                return 1'b1;
            end
            REQ_UPD: begin
                p  = ((rate * node_act) >>> 16) * a >>> 16;
                m  = (mom * w_delta[k]) >>> 16;
                nd = clamp24(p + m);
                w_delta[k] = nd;
                out_w[k]   = clamp24(out_w[k] + nd);
                y.result_kind  = KIND_WGT;
                y.result_index = r.conn_index;
                y.result_value = out_w[k][23:0];
                return 1'b1;
            end
            REQ_LOAD: begin
                out_w[k]   = a;
                w_delta[k] = 0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Monitor: check results first, then record the request taken at this edge,
    // so a result and a new request on the same edge keep their order.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        bit   due;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid) begin
                moved = 1'b1;
                got = o_rsp;
                if (owed_results.size() == 0) begin
                    $error("unexpected result kind=%0d value=%0d",
                           got.result_kind, got.result_value);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (got.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, got.result_kind);
                        errors++;
                    end
                    if (got.result_index !== want.result_index) begin
                        $error("result_index: expected %0d, got %0d",
                               want.result_index, got.result_index);
                        errors++;
                    end
                    if (got.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, got.result_value);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                req_taken = 1'b1;
                n_taken++;
                due = neuron_step(i_req, want);
                if (due) owed_results = {owed_results, want};
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // Driver: hold a request until taken, then issue the next one in bursts
    // separated by random gaps. At most one assignment to start per edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // hold the current request
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            i_req <= pending_reqs.pop_front();
            start <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                // one burst in four runs back to back
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog: no handshake for %0d cycles", STALL_MAX);
            $display("simulation failed");
            $finish;
        end
    end

    // Operand mix: full range, up to two in magnitude (keeps tanh off its rails), tiny, rails.
    function automatic logic signed [23:0] pick_q();
        case ($urandom_range(0, 5))
            0:       return 24'(Q_MAX);
            1:       return 24'(Q_MIN);
            2:       return 24'($urandom_range(0, 262143) - 131072);
            3:       return 24'($urandom_range(0, 2047) - 1024);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] kind, input int k,
                             input logic signed [23:0] a, input logic signed [23:0] b,
                             input bit last);
        t_req r;
        r.req_type   = kind;
        r.conn_index = 4'(k);
        r.operand_a  = a;
        r.operand_b  = b;
        r.last_term  = last;
        pending_reqs = {pending_reqs, r};
    endtask

    // Random stream: mostly complete runs with random content, some noise.
    task automatic queue_random(input int count);
        int made, len, sel;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    queue_req(REQ_FWD, $urandom_range(0, 15), pick_q(), pick_q(), i == len - 1);
                made += len;
            end else if (sel < 45) begin
                queue_req(REQ_OGRAD, $urandom_range(0, 15), pick_q(), pick_q(),
                          1'($urandom_range(0, 1)));
                made++;
            end else if (sel < 63) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    queue_req(REQ_HGRAD, $urandom_range(0, 15), pick_q(), pick_q(), i == len - 1);
                made += len;
            end else if (sel < 82) begin
                queue_req(REQ_UPD, $urandom_range(0, 15), pick_q(), pick_q(),
                          1'($urandom_range(0, 1)));
                made++;
            end else if (sel < 90) begin
                queue_req(REQ_LOAD, $urandom_range(0, 15), pick_q(), pick_q(),
                          1'($urandom_range(0, 1)));
                made++;
            end else if (sel < 95) begin
                // broken run: a lone non-final term left in the shared sum
                queue_req($urandom_range(0, 1) ? REQ_FWD : REQ_HGRAD, $urandom_range(0, 15),
                          pick_q(), pick_q(), 1'b0);
                made++;
            end else begin
                // unknown request codes are dropped by the unit
                queue_req(3'($urandom_range(5, 7)), $urandom_range(0, 15), pick_q(), pick_q(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || start || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write one register while idle and mirror it.
    task automatic write_cfg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LEARN_RATE:  rate    = val[16:0];
            CFG_MOMENTUM:    mom     = val[16:0];
            CFG_BIAS_WEIGHT: bias_w  = $signed(val);
            CFG_BIAS_INPUT:  bias_in = $signed(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LEARN_RATE;
        i_cfg_data = '0;
        errors     = 0;
        n_taken    = 0;
        n_checked  = 0;
        quiet_cycles = 0;
        req_taken  = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        rate     = LEARN_RATE_RST;
        mom      = MOMENTUM_RST;
        bias_w   = BIAS_WEIGHT_RST;
        bias_in  = BIAS_INPUT_RST;
        node_act = 0;
        node_grad = 0;
        acc      = 0;
        for (int i = 0; i < N_CONN; i++) begin
            out_w[i]   = 0;
            w_delta[i] = 0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: load every outgoing weight first so no read ever hits an
        // unwritten entry, rails on the first few.
        queue_req(REQ_LOAD, 0, 24'(Q_MAX), 24'sd0, 1'b0);
        queue_req(REQ_LOAD, 1, 24'(Q_MIN), 24'(Q_MAX), 1'b1);
        queue_req(REQ_LOAD, 2, 24'sd0, 24'sd0, 1'b0);
        queue_req(REQ_LOAD, 3, 24'sd65536, 24'sd0, 1'b0);
        for (int i = 4; i < N_CONN; i++)
            queue_req(REQ_LOAD, i, pick_q(), pick_q(), 1'b0);
        queue_req(REQ_FWD, 0, 24'(Q_MAX), 24'(Q_MAX), 1'b1);     // saturated sum, tanh rail
        queue_req(REQ_FWD, 0, 24'(Q_MIN), 24'(Q_MAX), 1'b0);     // non-final term
        queue_req(REQ_FWD, 0, 24'sd65536, 24'sd16384, 1'b1);     // closes the run above, tanh rail
        queue_req(REQ_OGRAD, 0, 24'(Q_MAX), 24'sd0, 1'b0);
        queue_req(REQ_HGRAD, 0, 24'(Q_MAX), 24'sd0, 1'b0);
        queue_req(REQ_HGRAD, 1, 24'(Q_MIN), 24'sd0, 1'b1);
        queue_req(REQ_UPD, 0, 24'(Q_MAX), 24'sd0, 1'b0);
        queue_req(REQ_UPD, 1, 24'(Q_MIN), 24'sd0, 1'b1);
        queue_req(3'd7, 15, 24'(Q_MIN), 24'(Q_MIN), 1'b1);       // unknown code, ignored
        drain();

        // Phase at reset defaults.
        queue_random(100);
        drain();

        // Phase at the top rails.
        write_cfg(CFG_LEARN_RATE, 24'd65536);
        write_cfg(CFG_MOMENTUM, 24'd65536);
        write_cfg(CFG_BIAS_WEIGHT, 24'h7FFFFF);
        write_cfg(CFG_BIAS_INPUT, 24'h800000);
        queue_random(100);
        drain();

        // Phase at the bottom rails; zero bias weight takes the bias term out of the sum.
        write_cfg(CFG_LEARN_RATE, 24'd0);
        write_cfg(CFG_MOMENTUM, 24'd0);
        write_cfg(CFG_BIAS_WEIGHT, 24'd0);
        write_cfg(CFG_BIAS_INPUT, 24'h800000);
        queue_random(100);
        drain();

        // Phase at random settings with a small bias.
        write_cfg(CFG_LEARN_RATE, 24'($urandom_range(0, 65536)));
        write_cfg(CFG_MOMENTUM, 24'($urandom_range(0, 65536)));
        write_cfg(CFG_BIAS_WEIGHT, 24'($urandom_range(0, 131072) - 65536));
        write_cfg(CFG_BIAS_INPUT, 24'($urandom_range(0, 131072) - 65536));
        queue_random(100);
        drain();

        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            errors++;
        end
        $display("covered %0d requests and %0d checked results at reset defaults",
                 n_taken, n_checked);
        $display("and three more register settings; errors found: %0d", errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tnb_pkg.sv
design/tnb_ram.sv
design/tnb_div.sv
design/tanh_neuron_backprop_unit.sv
test/tanh_neuron_backprop_unit_test.sv
